// ----- rtl/cdrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdrt_pkg: shared types and constants of the counter delta rate tracker
// Holds the sample kinds, event codes, state types and the request and
// status structs exchanged between the tracker and its rate unit.
// ----------------------------------------------------------------------------
package cdrt_pkg;

   // Sample kinds carried on the command field.
   localparam logic [1:0] CMD_GAUGE     = 2'd0;
   localparam logic [1:0] CMD_COUNTER32 = 2'd1;

   // Event codes reported with every result.
   localparam logic [2:0] EV_ZERO   = 3'd0;
   localparam logic [2:0] EV_GAUGE  = 3'd1;
   localparam logic [2:0] EV_NORMAL = 3'd2;
   localparam logic [2:0] EV_WRAP32 = 3'd3;
   localparam logic [2:0] EV_WRAP64 = 3'd4;
   localparam logic [2:0] EV_OBO    = 3'd5;
   localparam logic [2:0] EV_FIRST  = 3'd6;

   // Configuration register indexes.
   localparam logic CSR_WITH_ZEROS    = 1'b0;
   localparam logic CSR_STORE_ENABLED = 1'b1;

   // Milliseconds per second; the 16 fraction bits are a plain shift.
   localparam logic [9:0] MS_PER_SEC = 10'd1000;

   // Offset added to a 32-bit counter wrap.
   localparam logic [63:0] THIRTYTWO = 64'h0000_0001_0000_0000;

   // Width of the upper dividend word: delta * 1000 needs 74 bits, the
   // top 26 of which land above the 64-bit lower word after the shift.
   localparam int HI_W = 26;

   typedef enum logic [1:0] {
      S_IDLE,
      S_BUSY,
      S_DONE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      R_IDLE,
      R_MUL_LO,
      R_MUL_HI,
      R_SUM,
      R_CHECK,
      R_DIV
   } rate_state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] delta;
      logic [47:0] elapsed;
   } rate_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] rate;
   } rate_rsp_type;

endpackage

// ----- rtl/counter_delta_rate_tracker.sv -----
`timescale 1ns / 1ps
// From accept to result valid, a transaction with a rate passes the rate unit
// (two multiply steps, one add, one check, 64 divide steps; it stops at the check
// when that yields zero or saturates), its done register, S_DONE and the output
// register; any other goes through S_DONE to the output register. One at a time:
// the next transaction can be accepted in the cycle after the result loads.
// Reset clears the kept sample and time, sets with_zeros 0 and store_enabled 1.
// ----------------------------------------------------------------------------
// counter_delta_rate_tracker: polled counter delta and rate tracker
// Classifies each sample against the last one kept, forms the delta and
// event code, and has the rate unit compute the per-second rate.
// ----------------------------------------------------------------------------
module counter_delta_rate_tracker
   import cdrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_sample_value,
   input  logic [47:0] req_time_ms,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_store,
   output logic [63:0] rsp_delta,
   output logic [63:0] rsp_rate,
   output logic [2:0]  rsp_event_res,
   // Configuration port
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic        csr_write_data
);

   ctrl_state_type state_ff, state_in;
   logic           with_zeros_ff, store_enabled_ff;
   logic [63:0]    prev_value_ff;
   logic [47:0]    prev_time_ff;

   logic [63:0]    item_delta_ff;
   logic [2:0]     item_event_ff;
   logic           item_store_ff;
   logic           item_rate_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_store_ff;
   logic [63:0]    rsp_delta_ff;
   logic [63:0]    rsp_rate_ff;
   logic [2:0]     rsp_event_ff;

   logic           accept;
   logic           load_out;
   logic [63:0]    diff;
   logic [47:0]    elapsed;
   logic           gauge;
   logic [63:0]    cls_delta;
   logic [2:0]     cls_event;
   logic           cls_dropped;
   logic           cls_rate;
   logic           cls_store;

   rate_req_type   rate_req;
   rate_rsp_type   rate_rsp;

   assign accept = req_valid & req_ready;

   // Classification of the incoming sample against the kept one.
   assign diff    = req_sample_value - prev_value_ff;
   assign elapsed = req_time_ms - prev_time_ff;
   assign gauge   = (req_command == CMD_GAUGE);

   always_comb begin
      cls_delta   = 64'h0;
      cls_event   = EV_ZERO;
      cls_dropped = 1'b0;
      cls_rate    = 1'b0;
      priority if (diff == 64'h0) begin
         cls_event = EV_ZERO;
         if (with_zeros_ff) begin
            cls_delta = gauge ? req_sample_value : 64'h0;
         end else begin
            cls_dropped = 1'b1;
         end
      end else if (gauge) begin
         cls_event = EV_GAUGE;
         cls_delta = req_sample_value;
      end else if (req_sample_value < prev_value_ff) begin
         // Backward by exactly one shows up as an all-ones difference.
         priority if (diff == '1) begin
            cls_event = EV_OBO;
         end else if (req_command == CMD_COUNTER32) begin
            cls_event = EV_WRAP32;
            cls_delta = diff + THIRTYTWO;
            cls_rate  = 1'b1;
         end else begin
            cls_event = EV_WRAP64;
            cls_delta = diff;
            cls_rate  = 1'b1;
         end
      end else if (prev_time_ff != 48'h0) begin
         cls_event = EV_NORMAL;
         cls_delta = diff;
         cls_rate  = 1'b1;
      end else begin
         cls_event   = EV_FIRST;
         cls_dropped = 1'b1;
      end
   end

   assign cls_store = ~cls_dropped & store_enabled_ff &
                      ((cls_delta != 64'h0) | with_zeros_ff);

   // Rate unit request is issued with the accepted transaction.
   assign rate_req.start   = accept & cls_rate;
   assign rate_req.delta   = cls_delta;
   assign rate_req.elapsed = elapsed;

   cdrt_rate_unit u_rate (
      .clock (clock),
      .reset (reset),
      .req   (rate_req),
      .rsp   (rate_rsp)
   );

   // Sequencer: accept, wait for the rate, hand the result to the output.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               state_in = cls_rate ? S_BUSY : S_DONE;
            end
         end
         S_BUSY: begin
            if (rate_rsp.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (~rsp_valid_ff | rsp_ready) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state, configuration and kept sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         with_zeros_ff    <= 1'b0;
         store_enabled_ff <= 1'b1;
         prev_value_ff    <= 64'h0;
         prev_time_ff     <= 48'h0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_WITH_ZEROS:    with_zeros_ff    <= csr_write_data;
               CSR_STORE_ENABLED: store_enabled_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (accept) begin
            prev_value_ff <= req_sample_value;
            prev_time_ff  <= req_time_ms;
         end
      end
   end

   // Per-transaction results and the output register.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_delta_ff <= cls_delta;
         item_event_ff <= cls_event;
         item_store_ff <= cls_store;
         item_rate_ff  <= cls_rate;
      end
      if (load_out) begin
         rsp_store_ff <= item_store_ff;
         rsp_delta_ff <= item_delta_ff;
         rsp_rate_ff  <= item_rate_ff ? rate_rsp.rate : 64'h0;
         rsp_event_ff <= item_event_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_store     = rsp_store_ff;
   assign rsp_delta     = rsp_delta_ff;
   assign rsp_rate      = rsp_rate_ff;
   assign rsp_event_res = rsp_event_ff;

endmodule

// ----- rtl/cdrt_rate_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdrt_rate_unit: iterative rate calculator
// Computes floor(delta * 1000 * 65536 / elapsed) saturated to 64 bits with
// one shared 32x10 multiplier and one shared subtractor under a small
// sequencer, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cdrt_rate_unit
   import cdrt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rate_req_type req,
   output rate_rsp_type rsp
);

   rate_state_type    state_ff, state_in;
   logic [63:0]       delta_ff, delta_in;
   logic [47:0]       elapsed_ff, elapsed_in;
   logic [41:0]       prod_lo_ff, prod_lo_in;
   logic [41:0]       prod_hi_ff, prod_hi_in;
   logic [HI_W-1:0]   hi_ff, hi_in;
   logic [63:0]       lo_ff, lo_in;
   logic [47:0]       rem_ff, rem_in;
   logic [63:0]       quo_ff, quo_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [63:0]       rate_ff, rate_in;
   logic              done_ff, done_in;

   logic [31:0]       mul_a;
   logic [41:0]       mul_p;
   logic [73:0]       sum;
   logic [48:0]       shifted;
   logic [49:0]       diff;
   logic              fits;

   // Shared multiplier: one 32-bit half of delta times 1000 per cycle.
   assign mul_a = (state_ff == R_MUL_HI) ? delta_ff[63:32] : delta_ff[31:0];
   assign mul_p = 42'(mul_a) * 42'(MS_PER_SEC);

   // Recombine the two partial products into delta * 1000.
   assign sum = 74'(prod_lo_ff) + {prod_hi_ff, 32'h0};

   // Shared subtractor for one restoring division step.
   assign shifted = {rem_ff, lo_ff[63]};
   assign diff    = {1'b0, shifted} - {2'b00, elapsed_ff};
   assign fits    = ~diff[49];

   // Sequencer and datapath next values.
   always_comb begin
      state_in   = state_ff;
      delta_in   = delta_ff;
      elapsed_in = elapsed_ff;
      prod_lo_in = prod_lo_ff;
      prod_hi_in = prod_hi_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      rate_in    = rate_ff;
      done_in    = 1'b0;
      unique case (state_ff)
         R_IDLE: begin
            if (req.start) begin
               delta_in   = req.delta;
               elapsed_in = req.elapsed;
               state_in   = R_MUL_LO;
            end
         end
         R_MUL_LO: begin
            prod_lo_in = mul_p;
            state_in   = R_MUL_HI;
         end
         R_MUL_HI: begin
            prod_hi_in = mul_p;
            state_in   = R_SUM;
         end
         R_SUM: begin
            // Dividend is (delta * 1000) << 16, split into hi and lo words.
            hi_in    = sum[73:48];
            lo_in    = {sum[47:0], 16'h0};
            state_in = R_CHECK;
         end
         R_CHECK: begin
            // A zero delta gives zero; a quotient that cannot fit saturates.
            priority if (delta_ff == 64'h0) begin
               rate_in  = 64'h0;
               done_in  = 1'b1;
               state_in = R_IDLE;
            end else if (48'(hi_ff) >= elapsed_ff) begin
               rate_in  = '1;
               done_in  = 1'b1;
               state_in = R_IDLE;
            end else begin
               rem_in   = 48'(hi_ff);
               quo_in   = 64'h0;
               cnt_in   = 6'd63;
               state_in = R_DIV;
            end
         end
         R_DIV: begin
            rem_in = fits ? diff[47:0] : shifted[47:0];
            quo_in = {quo_ff[62:0], fits};
            lo_in  = {lo_ff[62:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               rate_in  = {quo_ff[62:0], fits};
               done_in  = 1'b1;
               state_in = R_IDLE;
            end
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      delta_ff   <= delta_in;
      elapsed_ff <= elapsed_in;
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      rate_ff    <= rate_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rate = rate_ff;

endmodule

// ----- sim/counter_delta_rate_tracker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_delta_rate_tracker_tb: self-checking bench for the rate tracker
// Feeds polled samples of every kind through the request channel. A short
// table of corner cases comes first, then long random runs under several
// register settings. Each result transaction is checked field by field
// against the typed table entry or a local tracker model of the kept sample and time.
// ----------------------------------------------------------------------------
module counter_delta_rate_tracker_tb;
   import cdrt_pkg::*;

   // Command codes that the package leaves out; code 3 acts as counter64.
   localparam logic [1:0]  CMD_COUNTER64     = 2'd2;
   localparam logic [1:0]  CMD_COUNTER64_ALT = 2'd3;
   localparam logic [63:0] ALL_ONES          = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [47:0] TIME_MAX          = 48'hFFFF_FFFF_FFFF;
   // One second in ms times the 16 fraction bits of the rate.
   localparam logic [127:0] RATE_SCALE       = 128'd65536000;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 130;
   localparam int PHASE_COUNT    = 5;
   localparam int END_CYCLES     = 100;

   typedef struct packed {
      logic        store;
      logic [63:0] delta;
      logic [63:0] rate;
      logic [2:0]  ev;
   } poll_result_type;

   // One stimulus row; the expected fields count only when typed is set.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] value;
      logic [47:0] tms;
      logic        typed;
      logic        store;
      logic [63:0] delta;
      logic [63:0] rate;
      logic [2:0]  ev;
   } poll_row_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command    = CMD_GAUGE;
   logic [63:0] req_sample_value = 64'd0;
   logic [47:0] req_time_ms    = 48'd0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic        rsp_store;
   logic [63:0] rsp_delta;
   logic [63:0] rsp_rate;
   logic [2:0]  rsp_event_res;
   logic        csr_write_en   = 1'b0;
   logic        csr_index      = CSR_WITH_ZEROS;
   logic        csr_write_data = 1'b0;

   // Tracker model state and register copies, at their reset values.
   logic [63:0] kept_value      = 64'd0;
   logic [47:0] kept_time       = 48'd0;
   logic        cfg_with_zeros  = 1'b0;
   logic        cfg_store_en    = 1'b1;

   poll_result_type expected_polls[$];
   int  mismatch_count = 0;
   int  idle_cycles    = 0;
   int  stall_left     = 0;
   bit  send_burst     = 1'b0;
   bit  ready_burst    = 1'b0;

   // Corner cases, walked in order right after reset.
   poll_row_type directed_rows [23] = '{
      // First poll of a counter is dropped, twice while the kept time is zero.
      '{CMD_COUNTER64, 64'h5, 48'd0, 1'b1, 1'b0, 64'd0, 64'd0, EV_FIRST},
      '{CMD_COUNTER32, 64'hA, 48'd1000, 1'b1, 1'b0, 64'd0, 64'd0, EV_FIRST},
      '{CMD_COUNTER64, 64'hA, 48'd2000, 1'b1, 1'b0, 64'd0, 64'd0, EV_ZERO},
      '{CMD_COUNTER64, 64'd1010, 48'd3000, 1'b1, 1'b1, 64'd1000, 64'd65536000,
        EV_NORMAL},
      '{CMD_COUNTER64, 64'd1009, 48'd4000, 1'b1, 1'b0, 64'd0, 64'd0, EV_OBO},
      '{CMD_GAUGE, ALL_ONES, 48'd5000, 1'b1, 1'b1, ALL_ONES, 64'd0, EV_GAUGE},
      '{CMD_GAUGE, ALL_ONES, 48'd6000, 1'b1, 1'b0, 64'd0, 64'd0, EV_ZERO},
      '{CMD_COUNTER32, 64'hFFFF_FFF0, 48'd7000, 1'b0, 1'b0, 64'd0, 64'd0, EV_ZERO},
      '{CMD_COUNTER32, 64'h20, 48'd8000, 1'b0, 1'b0, 64'd0, 64'd0, EV_ZERO},
      '{CMD_COUNTER64, 64'h10, 48'd9000, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0,
        ALL_ONES, EV_WRAP64},
      // Zero elapsed time saturates the rate.
      '{CMD_COUNTER64, 64'h20, 48'd9000, 1'b1, 1'b1, 64'h10, ALL_ONES, EV_NORMAL},
      '{CMD_COUNTER64_ALT, 64'h1F, 48'd10000, 1'b1, 1'b0, 64'd0, 64'd0, EV_OBO},
      '{CMD_COUNTER64_ALT, 64'h10, 48'd11000, 1'b0, 1'b0, 64'd0, 64'd0, EV_ZERO},
      '{CMD_COUNTER64, ALL_ONES, TIME_MAX, 1'b0, 1'b0, 64'd0, 64'd0, EV_ZERO},
      // Both the counter and the timestamp wrap here.
      '{CMD_COUNTER64, 64'h0, 48'd999, 1'b1, 1'b1, 64'd1, 64'd65536, EV_WRAP64},
      '{CMD_COUNTER64, 64'h1_0000_0005, 48'd2000, 1'b0, 1'b0, 64'd0, 64'd0,
        EV_ZERO},
      // A 32-bit wrap that comes out to zero has no rate.
      '{CMD_COUNTER32, 64'h5, 48'd3000, 1'b1, 1'b0, 64'd0, 64'd0, EV_WRAP32},
      '{CMD_GAUGE, 64'h0, 48'd4000, 1'b1, 1'b0, 64'd0, 64'd0, EV_GAUGE},
      '{CMD_COUNTER64, 64'h0000_FFFF_FFFF_FFFF, 48'd4001, 1'b1, 1'b1,
        64'h0000_FFFF_FFFF_FFFF, ALL_ONES, EV_NORMAL},
      '{CMD_COUNTER64, 64'h0001_0000_0000_0000, 48'd4008, 1'b0, 1'b0, 64'd0,
        64'd0, EV_ZERO},
      '{CMD_COUNTER64, 64'h0001_0000_0000_0005, 48'd0, 1'b0, 1'b0, 64'd0, 64'd0,
        EV_ZERO},
      '{CMD_COUNTER32, 64'h0001_0000_0000_0009, 48'd500, 1'b1, 1'b0, 64'd0, 64'd0,
        EV_FIRST},
      '{CMD_COUNTER32, 64'h0001_0000_0000_0010, 48'd1500, 1'b0, 1'b0, 64'd0,
        64'd0, EV_ZERO}
   };

   counter_delta_rate_tracker uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_sample_value (req_sample_value),
      .req_time_ms      (req_time_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_store        (rsp_store),
      .rsp_delta        (rsp_delta),
      .rsp_rate         (rsp_rate),
      .rsp_event_res    (rsp_event_res),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   // Delta per second in 48.16 fixed point, truncated and saturated.
   function automatic logic [63:0] rate_fixed(logic [63:0] delta, logic [47:0] elapsed);
      logic [127:0] quot;
      if (delta == 64'd0)
         return 64'd0;
      if (elapsed == 48'd0)
         return ALL_ONES;
      quot = ({64'd0, delta} * RATE_SCALE) / {80'd0, elapsed};
      if (quot[127:64] != 64'd0)
         return ALL_ONES;
      return quot[63:0];
   endfunction

   // Classify one sample against the kept one, then keep the new sample.
   function automatic poll_result_type predict_poll(logic [1:0] cmd, logic [63:0] value,
                                                    logic [47:0] tms);
      poll_result_type res;
      logic [47:0]     elapsed;
      logic            dropped;
      res     = '0;
      dropped = 1'b0;
      elapsed = tms - kept_time;
      if (value == kept_value) begin
         res.ev = EV_ZERO;
         if (cfg_with_zeros)
            res.delta = (cmd == CMD_GAUGE) ? value : 64'd0;
         else
            dropped = 1'b1;
      end else if (cmd == CMD_GAUGE) begin
         res.ev    = EV_GAUGE;
         res.delta = value;
      end else if (value < kept_value) begin
         if (kept_value - value == 64'd1) begin
            res.ev = EV_OBO;
         end else if (cmd == CMD_COUNTER32) begin
            res.ev    = EV_WRAP32;
            res.delta = (THIRTYTWO - kept_value) + value;
            res.rate  = rate_fixed(res.delta, elapsed);
         end else begin
            res.ev    = EV_WRAP64;
            res.delta = value - kept_value;
            res.rate  = rate_fixed(res.delta, elapsed);
         end
      end else if (kept_time != 48'd0) begin
         res.ev    = EV_NORMAL;
         res.delta = value - kept_value;
         res.rate  = rate_fixed(res.delta, elapsed);
      end else begin
         res.ev  = EV_FIRST;
         dropped = 1'b1;
      end
      res.store  = !dropped && cfg_store_en && (res.delta != 64'd0 || cfg_with_zeros);
      kept_value = value;
      kept_time  = tms;
      return res;
   endfunction

   // Idle stretch: mostly short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Sample values mostly follow the kept one so every event shows up.
   function automatic logic [63:0] pick_value(logic [1:0] cmd, logic [63:0] last);
      logic [63:0] v;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 35)
         v = last + 64'($urandom_range(1, 65536));
      else if (r < 45)
         v = last + {32'd0, $urandom};
      else if (r < 50)
         v = last + rand64();
      else if (r < 60)
         v = last;
      else if (r < 68)
         v = last - 64'd1;
      else if (r < 80)
         v = last - 64'($urandom_range(2, 1 << 20));
      else if (r < 92)
         v = rand64();
      else begin
         case ($urandom_range(0, 3))
            0: v = 64'd0;
            1: v = ALL_ONES;
            2: v = 64'hFFFF_FFFF;
            default: v = THIRTYTWO;
         endcase
      end
      // Keep a 32-bit counter inside 32 bits most of the time.
      if (cmd == CMD_COUNTER32 && last[63:32] == 32'd0 && $urandom_range(0, 1) == 1)
         v[63:32] = 32'd0;
      return v;
   endfunction

   function automatic logic [47:0] pick_time(logic [47:0] last);
      logic [31:0] upper;
      int          r;
      r = $urandom_range(0, 99);
      upper = $urandom;
      if (r < 70)
         return last + 48'($urandom_range(1, 10000));
      else if (r < 78)
         return last;
      else if (r < 83)
         return 48'd0;
      else if (r < 93)
         return {upper[15:0], $urandom};
      return TIME_MAX - 48'($urandom_range(0, 5000));
   endfunction

   function automatic poll_row_type random_row();
      poll_row_type row;
      int           r;
      row = '0;
      r = $urandom_range(0, 99);
      if (r < 20)
         row.cmd = CMD_GAUGE;
      else if (r < 55)
         row.cmd = CMD_COUNTER32;
      else if (r < 90)
         row.cmd = CMD_COUNTER64;
      else
         row.cmd = CMD_COUNTER64_ALT;
      row.value = pick_value(row.cmd, kept_value);
      row.tms   = pick_time(kept_time);
      return row;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Offer one sample transaction and record its expected result on accept.
   task automatic send_sample(poll_row_type row);
      poll_result_type res;
      int              gap;
      if ($urandom_range(0, 49) == 0)
         send_burst = !send_burst;
      gap = (send_burst || $urandom_range(0, 1) == 0) ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= row.cmd;
      req_sample_value <= row.value;
      req_time_ms      <= row.tms;
      do @(posedge clock); while (!req_ready);
      res = predict_poll(row.cmd, row.value, row.tms);
      if (row.typed) begin
         res.store = row.store;
         res.delta = row.delta;
         res.rate  = row.rate;
         res.ev    = row.ev;
      end
      expected_polls.push_back(res);
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic drain_polls(int extra);
      req_valid <= 1'b0;
      while (expected_polls.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // One register write; the enable drops on the following edge.
   task automatic write_csr(logic index, logic data);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= data;
      @(posedge clock);
      if (index == CSR_WITH_ZEROS)
         cfg_with_zeros = data;
      else
         cfg_store_en = data;
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: random back-pressure and the field-by-field check.
   always @(posedge clock) begin
      poll_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_polls.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_delta, 64'd0);
         end else begin
            want = expected_polls.pop_front();
            if (rsp_store !== want.store)
               report_mismatch("store", {63'd0, rsp_store}, {63'd0, want.store});
            if (rsp_delta !== want.delta)
               report_mismatch("delta", rsp_delta, want.delta);
            if (rsp_rate !== want.rate)
               report_mismatch("rate", rsp_rate, want.rate);
            if (rsp_event_res !== want.ev)
               report_mismatch("event", {61'd0, rsp_event_res}, {61'd0, want.ev});
         end
      end
      if ($urandom_range(0, 199) == 0)
         ready_burst = !ready_burst;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!ready_burst && $urandom_range(0, 3) == 0) begin
         stall_left = idle_length() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: too long without any transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Main sequence: reset, directed table, then random phases.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_sample(directed_rows[i]);
      drain_polls(4);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_WITH_ZEROS, 1'b1);
               write_csr(CSR_STORE_ENABLED, 1'b1);
            end
            1: begin
               write_csr(CSR_WITH_ZEROS, 1'b1);
               write_csr(CSR_STORE_ENABLED, 1'b0);
            end
            2: begin
               write_csr(CSR_WITH_ZEROS, 1'b0);
               write_csr(CSR_STORE_ENABLED, 1'b0);
            end
            3: begin
               write_csr(CSR_WITH_ZEROS, 1'b0);
               write_csr(CSR_STORE_ENABLED, 1'b1);
            end
            default: begin
               write_csr(CSR_WITH_ZEROS, 1'($urandom_range(0, 1)));
               write_csr(CSR_STORE_ENABLED, 1'($urandom_range(0, 1)));
            end
         endcase
         repeat (PHASE_ITEMS) send_sample(random_row());
         drain_polls(4);
      end

      drain_polls(END_CYCLES);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/cdrt_pkg.sv
rtl/cdrt_rate_unit.sv
rtl/counter_delta_rate_tracker.sv
sim/counter_delta_rate_tracker_tb.sv
